// ===== sv/assert_macros.svh =====
// assertion macros used by key_gesture_classifier
// no dependencies; synthesis builds define SYNTH and get empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define KGC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define KGC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define KGC_ASSERT(lbl, clk, rst_n, prop)
`define KGC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/kgc_pkg.sv =====
// types, codes and constants of the key gesture classifier
// no dependencies
package kgc_pkg;

  localparam int NUM_KEYS = 4;
  localparam int KEY_W    = 2;
  localparam int AGE_W    = 16;
  localparam int MASK_W   = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [AGE_W-1:0] AGE_MAX    = '1;
  localparam logic [AGE_W-1:0] LONG_FLOOR = AGE_W'(100);
  localparam logic [KEY_W-1:0] LAST_KEY   = KEY_W'(NUM_KEYS - 1);

  // input actions
  localparam logic [1:0] ACT_TICK    = 2'd0;
  localparam logic [1:0] ACT_PRESS   = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;
  localparam logic [1:0] ACT_REPEAT  = 2'd3;

  // gesture codes
  localparam logic [1:0] G_SHORT  = 2'd0;
  localparam logic [1:0] G_LONG   = 2'd1;
  localparam logic [1:0] G_DOUBLE = 2'd2;
  localparam logic [1:0] G_TRIPLE = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WATCHED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIPLE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_HOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_GAP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ON = 3'd5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROC,
    S_FLUSH
  } fsm_t;

  typedef struct packed {
    logic             held;
    logic             long_done;
    logic [AGE_W-1:0] hold_age;
    logic [1:0]       tap_count;
    logic             run_pending;
    logic [AGE_W-1:0] gap_age;
  } key_state_t;

  typedef struct packed {
    logic [KEY_W-1:0] gesture_key;
    logic [1:0]       gesture;
    logic             reinject;
  } result_t;

  typedef struct packed {
    logic [MASK_W-1:0] watched_mask;
    logic [MASK_W-1:0] double_mask;
    logic [MASK_W-1:0] triple_mask;
    logic [AGE_W-1:0]  long_hold_ms;
    logic [AGE_W-1:0]  tap_gap_ms;
    logic              screen_on;
  } cfg_t;

  // sequencer to result queue
  typedef struct packed {
    logic push;
    logic flush;
  } q_ctrl_t;

  // result queue back to sequencer
  typedef struct packed {
    logic push_ok;
    logic flush_ok;
    logic stash_valid;
  } q_stat_t;

  function automatic logic [1:0] run_gesture(input logic [1:0] cnt);
    logic [1:0] g;
    if (cnt == 2'd3) begin
      g = G_TRIPLE;
    end else if (cnt == 2'd2) begin
      g = G_DOUBLE;
    end else begin
      g = G_SHORT;
    end
    return g;
  endfunction

endpackage

// ===== sv/kgc_state_ram.sv =====
// per-key state memory, registered read, valid bit per entry
// depends on kgc_pkg
module kgc_state_ram (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      re,
  input  logic [kgc_pkg::KEY_W-1:0] raddr,
  output kgc_pkg::key_state_t       rdata,
  input  logic                      we,
  input  logic [kgc_pkg::KEY_W-1:0] waddr,
  input  kgc_pkg::key_state_t       wdata
);
  import kgc_pkg::*;

  key_state_t          mem [NUM_KEYS];
  key_state_t          rd_r;
  logic [NUM_KEYS-1:0] vld_r;
  logic                rd_vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_r <= mem[raddr];
    end
  end

  // entries never written since reset read as all zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (re) begin
        rd_vld_r <= vld_r[raddr];
      end
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
    end
  end

  assign rdata = rd_vld_r ? rd_r : '0;

endmodule

// ===== sv/kgc_key_update.sv =====
// next state and gesture of one key for a tick, press or release
// depends on kgc_pkg
module kgc_key_update (
  input  logic [1:0]                action,
  input  logic [kgc_pkg::KEY_W-1:0] key,
  input  kgc_pkg::cfg_t             cfg,
  input  kgc_pkg::key_state_t       cur,
  output kgc_pkg::key_state_t       nxt,
  output logic                      fire,
  output kgc_pkg::result_t          res
);
  import kgc_pkg::*;

  logic [AGE_W-1:0] lim;
  logic [AGE_W-1:0] h_age;
  logic [AGE_W-1:0] g_age;
  logic [1:0]       cnt;
  logic [1:0]       key_lim;
  logic [1:0]       gest;

  always_comb begin
    lim = (cfg.long_hold_ms < LONG_FLOOR) ? LONG_FLOOR : cfg.long_hold_ms;
    h_age = (cur.held && cur.hold_age != AGE_MAX) ? cur.hold_age + 1'b1 : cur.hold_age;
    g_age = (cur.run_pending && cur.gap_age != AGE_MAX) ? cur.gap_age + 1'b1
                                                         : cur.gap_age;
    // tap count wraps past three back to three
    cnt = cur.tap_count + 1'b1;
    if (cnt == 2'd0) begin
      cnt = 2'd3;
    end
    if (cfg.triple_mask[key]) begin
      key_lim = 2'd3;
    end else if (cfg.double_mask[key]) begin
      key_lim = 2'd2;
    end else begin
      key_lim = 2'd1;
    end

    nxt  = cur;
    fire = 1'b0;
    gest = G_SHORT;

    unique case (action)
      ACT_TICK: begin
        nxt.hold_age = h_age;
        nxt.gap_age  = g_age;
        if (cur.held && !cur.long_done && h_age >= lim) begin
          // long press cancels the tap run
          nxt.long_done   = 1'b1;
          nxt.tap_count   = 2'd0;
          nxt.run_pending = 1'b0;
          nxt.gap_age     = '0;
          fire = 1'b1;
          gest = G_LONG;
        end else if (cur.run_pending && g_age > cfg.tap_gap_ms) begin
          nxt.tap_count   = 2'd0;
          nxt.run_pending = 1'b0;
          nxt.gap_age     = '0;
          fire = 1'b1;
          gest = run_gesture(cur.tap_count);
        end
      end
      ACT_PRESS: begin
        nxt.held      = 1'b1;
        nxt.long_done = 1'b0;
        nxt.hold_age  = '0;
      end
      ACT_RELEASE: begin
        if (!cur.long_done) begin
          nxt.gap_age = '0;
          if (cnt >= key_lim) begin
            nxt.tap_count   = 2'd0;
            nxt.run_pending = 1'b0;
            fire = 1'b1;
            gest = run_gesture(cnt);
          end else begin
            nxt.tap_count   = cnt;
            nxt.run_pending = 1'b1;
          end
        end
        nxt.held      = 1'b0;
        nxt.long_done = 1'b0;
        nxt.hold_age  = '0;
      end
      ACT_REPEAT: begin
        nxt = cur;
      end
      default: begin
        nxt = cur;
      end
    endcase

    res.gesture_key = key;
    res.gesture     = gest;
    res.reinject    = (gest == G_SHORT) && !cfg.screen_on;
  end

endmodule

// ===== sv/kgc_result_q.sv =====
// result stash and output register; the stash holds back one word so the
// final result of an item can carry tlast. depends on kgc_pkg
module kgc_result_q (
  input  logic              clk,
  input  logic              rst_n,
  input  kgc_pkg::q_ctrl_t  ctrl,
  input  kgc_pkg::result_t  push_res,
  output kgc_pkg::q_stat_t  stat,
  output logic              out_valid,
  input  logic              out_ready,
  output kgc_pkg::result_t  out_res,
  output logic              out_last
);
  import kgc_pkg::*;

  result_t st_r;
  logic    st_v_r;
  result_t out_res_r;
  logic    out_last_r;
  logic    out_v_r;
  logic    out_free;
  logic    load_push;
  logic    load_flush;

  assign out_free   = !out_v_r || out_ready;
  assign load_push  = ctrl.push && st_v_r && out_free;
  assign load_flush = ctrl.flush && st_v_r && out_free;

  assign stat.push_ok     = !st_v_r || out_free;
  assign stat.flush_ok    = !st_v_r || out_free;
  assign stat.stash_valid = st_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (load_push || load_flush) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
      if (ctrl.push && stat.push_ok) begin
        st_v_r <= 1'b1;
      end else if (load_flush) begin
        st_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_push || load_flush) begin
      out_res_r  <= st_r;
      out_last_r <= load_flush;
    end
    if (ctrl.push && stat.push_ok) begin
      st_r <= push_res;
    end
  end

  assign out_valid = out_v_r;
  assign out_res   = out_res_r;
  assign out_last  = out_last_r;

endmodule

// ===== sv/key_gesture_classifier.sv =====
// Key gesture classifier: per-key state sits in a small synchronous memory
// that is read, updated and written back one key a cycle unless the result
// queue stalls. A press, release or autorepeat passes read, update and close;
// a tick reads, updates and writes back every key in turn before the close.
// A new word is taken only when the previous one is finished. A full output
// stage stalls the update and close steps while the stash holds a word.
// Configuration writes are taken at any time but are meant for an idle block.
// depends on kgc_pkg, kgc_state_ram, kgc_key_update, kgc_result_q, assert_macros.svh
`include "assert_macros.svh"

module key_gesture_classifier (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [1:0] key_index, rest zero
  input  logic [1:0]                    in_tuser,   // [1:0] action
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // [1:0] gesture_key, [2] reinject
  output logic [1:0]                    out_tuser,  // [1:0] gesture
  output logic                          out_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kgc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kgc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import kgc_pkg::*;

  cfg_t             cfg_r;
  fsm_t             state_r, state_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [1:0]       act_r, act_nxt;
  logic             do_r, do_nxt;

  logic             mem_re, mem_we;
  logic [KEY_W-1:0] mem_raddr;
  key_state_t       mem_rdata, upd_state;
  logic             fire, stall;
  result_t          upd_res, out_res;
  q_ctrl_t          q_ctrl;
  q_stat_t          q_stat;
  logic             in_applies;
  logic [KEY_W-1:0] in_key;
  logic             out_last;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.watched_mask <= '0;
      cfg_r.double_mask  <= '0;
      cfg_r.triple_mask  <= '0;
      cfg_r.long_hold_ms <= AGE_W'(500);
      cfg_r.tap_gap_ms   <= AGE_W'(300);
      cfg_r.screen_on    <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WATCHED:   cfg_r.watched_mask <= cfg_data[MASK_W-1:0];
        CFG_DOUBLE:    cfg_r.double_mask  <= cfg_data[MASK_W-1:0];
        CFG_TRIPLE:    cfg_r.triple_mask  <= cfg_data[MASK_W-1:0];
        CFG_LONG_HOLD: cfg_r.long_hold_ms <= cfg_data[AGE_W-1:0];
        CFG_TAP_GAP:   cfg_r.tap_gap_ms   <= cfg_data[AGE_W-1:0];
        CFG_SCREEN_ON: cfg_r.screen_on    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_key = in_tdata[KEY_W-1:0];
  // ticks always apply; presses and releases only for watched keys, autorepeats never
  assign in_applies = (in_tuser == ACT_TICK) ||
                      (((in_tuser == ACT_PRESS) || (in_tuser == ACT_RELEASE)) &&
                       cfg_r.watched_mask[in_key]);

  kgc_state_ram u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .we    (mem_we),
    .waddr (key_r),
    .wdata (upd_state)
  );

  kgc_key_update u_upd (
    .action (act_r),
    .key    (key_r),
    .cfg    (cfg_r),
    .cur    (mem_rdata),
    .nxt    (upd_state),
    .fire   (fire),
    .res    (upd_res)
  );

  kgc_result_q u_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (q_ctrl),
    .push_res  (upd_res),
    .stat      (q_stat),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res),
    .out_last  (out_last)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    act_r <= act_nxt;
    do_r  <= do_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    key_nxt   = key_r;
    act_nxt   = act_r;
    do_nxt    = do_r;
    in_tready = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = key_r;
    mem_we    = 1'b0;
    q_ctrl    = '0;
    stall     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        mem_raddr = (in_tuser == ACT_TICK) ? '0 : in_key;
        if (in_tvalid) begin
          mem_re    = 1'b1;
          key_nxt   = mem_raddr;
          act_nxt   = in_tuser;
          do_nxt    = in_applies;
          state_nxt = S_PROC;
        end
      end
      S_PROC: begin
        stall       = do_r && fire && !q_stat.push_ok;
        q_ctrl.push = do_r && fire;
        if (!stall) begin
          mem_we = do_r;
          if (act_r == ACT_TICK && key_r != LAST_KEY) begin
            // fetch the next key while this one is written back
            key_nxt   = key_r + 1'b1;
            mem_raddr = key_nxt;
            mem_re    = 1'b1;
          end else begin
            state_nxt = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        q_ctrl.flush = 1'b1;
        if (q_stat.flush_ok) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_tdata = {5'b0, out_res.reinject, out_res.gesture_key};
  assign out_tuser = out_res.gesture;
  assign out_tlast = out_last;

  `KGC_ASSERT(a_no_same_entry_rw, clk, rst_n, !(mem_we && mem_re && (mem_raddr == key_r)))
  `KGC_ASSERT(a_stash_empty_idle, clk, rst_n, !((state_r == S_IDLE) && q_stat.stash_valid))
  `KGC_ASSERT_NEXT(a_tick_scan_order, clk, rst_n,
                   (state_r == S_PROC) && !stall && (act_r == ACT_TICK) && (key_r != LAST_KEY),
                   (state_r == S_PROC) && (key_r == $past(key_r) + 1'b1))

endmodule

// ===== verif/kgc_checker.sv =====
// kgc_checker: scoreboard for key_gesture_classifier, watches the word, result and
// register channels and predicts each gesture word from its own key state
// depends on kgc_pkg
module kgc_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [1:0] key_index, rest zero
  input  logic [1:0]                     in_tuser,   // [1:0] action
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [7:0]                     out_tdata,  // [1:0] gesture_key, [2] reinject
  input  logic [1:0]                     out_tuser,  // [1:0] gesture
  input  logic                           out_tlast,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [kgc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kgc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             due_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import kgc_pkg::*;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [1:0]       gesture;
    logic             reinject;
    logic             last;
  } gesture_word_t;

  logic [MASK_W-1:0] watch_bits;
  logic [MASK_W-1:0] double_bits;
  logic [MASK_W-1:0] triple_bits;
  logic [AGE_W-1:0]  long_hold;
  logic [AGE_W-1:0]  tap_gap;
  logic              screen_lit;

  logic             key_held      [NUM_KEYS];
  logic             key_long_seen [NUM_KEYS];
  logic [AGE_W-1:0] key_hold_age  [NUM_KEYS];
  logic [1:0]       key_taps      [NUM_KEYS];
  logic             key_run_open  [NUM_KEYS];
  logic [AGE_W-1:0] key_gap_age   [NUM_KEYS];

  gesture_word_t gestures_due [$];

  function automatic logic [1:0] run_kind(input logic [1:0] taps);
    logic [1:0] g;
    case (taps)
      2'd3:    g = G_TRIPLE;
      2'd2:    g = G_DOUBLE;
      default: g = G_SHORT;
    endcase
    return g;
  endfunction

  // triple wins over double
  function automatic logic [1:0] tap_cap(input logic [KEY_W-1:0] k);
    logic [1:0] cap;
    if (triple_bits[k]) begin
      cap = 2'd3;
    end else if (double_bits[k]) begin
      cap = 2'd2;
    end else begin
      cap = 2'd1;
    end
    return cap;
  endfunction

  function automatic gesture_word_t fired(input int k, input logic [1:0] g);
    gesture_word_t w;
    w.key      = KEY_W'(k);
    w.gesture  = g;
    w.reinject = (g == G_SHORT) && !screen_lit;
    w.last     = 1'b0;
    return w;
  endfunction

  task automatic clear_model();
    watch_bits  = '0;
    double_bits = '0;
    triple_bits = '0;
    long_hold   = AGE_W'(500);
    tap_gap     = AGE_W'(300);
    screen_lit  = 1'b1;
    for (int c = 0; c < NUM_KEYS; c++) begin
      key_held[c]      = 1'b0;
      key_long_seen[c] = 1'b0;
      key_hold_age[c]  = '0;
      key_taps[c]      = '0;
      key_run_open[c]  = 1'b0;
      key_gap_age[c]   = '0;
    end
    gestures_due.delete();
  endtask

  task automatic apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_WATCHED:   watch_bits  = d[MASK_W-1:0];
      CFG_DOUBLE:    double_bits = d[MASK_W-1:0];
      CFG_TRIPLE:    triple_bits = d[MASK_W-1:0];
      CFG_LONG_HOLD: long_hold   = d[AGE_W-1:0];
      CFG_TAP_GAP:   tap_gap     = d[AGE_W-1:0];
      CFG_SCREEN_ON: screen_lit  = d[0];
      default: ;
    endcase
  endtask

  task automatic predict_word(input logic [1:0] act, input logic [KEY_W-1:0] k);
    gesture_word_t burst [$];
    logic [AGE_W-1:0] lim;
    logic [1:0]       taps;
    lim = (long_hold < LONG_FLOOR) ? LONG_FLOOR : long_hold;
    if (act == ACT_TICK) begin
      for (int c = 0; c < NUM_KEYS; c++) begin
        if (key_held[c] && key_hold_age[c] != AGE_MAX) key_hold_age[c]++;
        if (key_run_open[c] && key_gap_age[c] != AGE_MAX) key_gap_age[c]++;
        // a long press cancels the tap run, so one word per key at most
        if (key_held[c] && !key_long_seen[c] && key_hold_age[c] >= lim) begin
          key_long_seen[c] = 1'b1;
          key_taps[c]      = '0;
          key_run_open[c]  = 1'b0;
          key_gap_age[c]   = '0;
          burst.push_back(fired(c, G_LONG));
        end
        if (key_run_open[c] && key_gap_age[c] > tap_gap) begin
          burst.push_back(fired(c, run_kind(key_taps[c])));
          key_taps[c]     = '0;
          key_run_open[c] = 1'b0;
          key_gap_age[c]  = '0;
        end
      end
    end else if ((act == ACT_PRESS || act == ACT_RELEASE) && watch_bits[k]) begin
      if (act == ACT_PRESS) begin
        key_held[k]      = 1'b1;
        key_long_seen[k] = 1'b0;
        key_hold_age[k]  = '0;
      end else begin
        if (!key_long_seen[k]) begin
          taps = key_taps[k] + 2'd1;
          if (taps == 2'd0) taps = 2'd3;
          if (taps >= tap_cap(k)) begin
            burst.push_back(fired(k, run_kind(taps)));
            key_taps[k]     = '0;
            key_run_open[k] = 1'b0;
            key_gap_age[k]  = '0;
          end else begin
            key_taps[k]     = taps;
            key_run_open[k] = 1'b1;
            key_gap_age[k]  = '0;
          end
        end
        key_held[k]      = 1'b0;
        key_long_seen[k] = 1'b0;
        key_hold_age[k]  = '0;
      end
    end
    if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
    foreach (burst[i]) gestures_due.push_back(burst[i]);
  endtask

  task automatic check_word();
    gesture_word_t want;
    gesture_word_t got;
    got.key      = out_tdata[KEY_W-1:0];
    got.gesture  = out_tuser;
    got.reinject = out_tdata[2];
    got.last     = out_tlast;
    if (gestures_due.size() == 0) begin
      fail_count++;
      $display("%0t: gesture word with none due: key %0d gesture %0d reinject %0b last %0b",
               $time, got.key, got.gesture, got.reinject, got.last);
    end else begin
      want = gestures_due.pop_front();
      if (got.key !== want.key) begin
        fail_count++;
        $display("%0t: gesture_key expected %0d, got %0d", $time, want.key, got.key);
      end
      if (got.gesture !== want.gesture) begin
        fail_count++;
        $display("%0t: gesture expected %0d, got %0d", $time, want.gesture, got.gesture);
      end
      if (got.reinject !== want.reinject) begin
        fail_count++;
        $display("%0t: reinject expected %0b, got %0b", $time, want.reinject, got.reinject);
      end
      if (got.last !== want.last) begin
        fail_count++;
        $display("%0t: last expected %0b, got %0b", $time, want.last, got.last);
      end
    end
  endtask

  // words due are pushed before the result side pops, both in edge order
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_model();
      due_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) apply_cfg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) predict_word(in_tuser, in_tdata[KEY_W-1:0]);
      if (out_tvalid && out_tready) check_word();
      due_count <= gestures_due.size();
    end
  end

endmodule

// ===== verif/tb_key_gesture_classifier.sv =====
// tb_key_gesture_classifier: stimulus and verdict for key_gesture_classifier
// directed gestures, then randomised tap and hold sequences under several register
// settings; depends on kgc_pkg, kgc_checker and the rtl
module tb_key_gesture_classifier;
  timeunit 1ns;
  timeprecision 1ps;
  import kgc_pkg::*;

  localparam int          CLK_HALF      = 2;
  localparam int          RESET_CYCLES  = 8;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          PHASE_STEPS   = 7;
  localparam int unsigned LIMIT_NS      = 10_000_000;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_COIN,
    SINK_SPARSE,
    SINK_BLINK
  } sink_mode_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = '0;   // [1:0] key_index, rest zero
  logic [1:0]            in_tuser   = '0;   // [1:0] action
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;         // [1:0] gesture_key, [2] reinject
  logic [1:0]            out_tuser;         // [1:0] gesture
  logic                  out_tlast;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  int fail_count;
  int due_count;

  int burst_left = 0;
  int burst_cap  = 12;
  int gap_cap    = 6;
  int tb_long    = 500;
  int tb_gap     = 300;

  sink_mode_t  sink_mode  = SINK_OPEN;
  int          sink_left  = 0;
  int unsigned sink_phase = 0;

  key_gesture_classifier uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  kgc_checker scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .due_count  (due_count)
  );

  always #(CLK_HALF) clk = ~clk;

  // result side: out_tready follows a randomly chosen stall mode, redrawn when its count runs out
  always @(posedge clk) begin
    if (sink_left == 0) begin
      sink_mode = sink_mode_t'($urandom_range(0, 3));
      sink_left = $urandom_range(8, 80);
    end else begin
      sink_left--;
    end
    sink_phase++;
    case (sink_mode)
      SINK_OPEN:   out_tready <= 1'b1;
      SINK_COIN:   out_tready <= 1'($urandom_range(0, 1));
      SINK_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
      default:     out_tready <= sink_phase[2];
    endcase
  end

  function automatic logic [KEY_W-1:0] pick_key();
    return KEY_W'($urandom_range(0, NUM_KEYS - 1));
  endfunction

  task automatic send_word(input logic [1:0] act, input logic [KEY_W-1:0] key);
    if (burst_left <= 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, gap_cap)) @(posedge clk);
      burst_left = $urandom_range(1, burst_cap);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {{(8 - KEY_W){1'b0}}, key};
    do @(posedge clk); while (!in_tready);
    burst_left--;
  endtask

  // hold off until every gesture due has arrived and a no-result word has drained
  task automatic settle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(input logic [MASK_W-1:0] watched, twice, thrice,
                              input logic [AGE_W-1:0] hold, gap, input logic screen);
    put_reg(CFG_WATCHED,   CFG_DATA_W'(watched));
    put_reg(CFG_DOUBLE,    CFG_DATA_W'(twice));
    put_reg(CFG_TRIPLE,    CFG_DATA_W'(thrice));
    put_reg(CFG_LONG_HOLD, CFG_DATA_W'(hold));
    put_reg(CFG_TAP_GAP,   CFG_DATA_W'(gap));
    put_reg(CFG_SCREEN_ON, CFG_DATA_W'(screen));
    cfg_valid <= 1'b0;
    tb_long = int'(hold);
    tb_gap  = int'(gap);
  endtask

  task automatic random_step();
    int pick;
    int lim;
    int gap_span;
    logic [KEY_W-1:0] key;
    pick     = $urandom_range(0, 99);
    key      = pick_key();
    lim      = (tb_long < 100) ? 100 : tb_long;
    gap_span = (tb_gap > 6) ? 6 : tb_gap;
    if (pick < 45) begin
      // tap run, sometimes broken up by a gap that is just too long
      repeat ($urandom_range(1, 3)) begin
        send_word(ACT_PRESS, key);
        repeat ($urandom_range(0, 2)) send_word(ACT_TICK, pick_key());
        send_word(ACT_RELEASE, key);
        repeat ($urandom_range(0, gap_span + 1)) send_word(ACT_TICK, pick_key());
      end
    end else if (pick < 50 && lim <= 130) begin
      send_word(ACT_PRESS, key);
      repeat ($urandom_range(lim - 2, lim + 2)) send_word(ACT_TICK, pick_key());
      if ($urandom_range(0, 3) != 0) send_word(ACT_RELEASE, key);
    end else if (pick < 68) begin
      repeat ($urandom_range(1, gap_span + 3)) send_word(ACT_TICK, pick_key());
    end else if (pick < 96) begin
      send_word(2'($urandom_range(0, 3)), key);
    end else begin
      settle();
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // keys 1 and 3 double, keys 2 and 3 triple, long hold below its floor, screen off
    program_regs(4'hA, 4'hA, 4'hC, 16'd0, 16'd0, 1'b0);
    program_regs(4'hF, 4'hA, 4'hC, 16'd0, 16'd0, 1'b0);
    send_word(ACT_REPEAT, 2'd0);
    send_word(ACT_PRESS, 2'd0);
    send_word(ACT_RELEASE, 2'd0);
    send_word(ACT_RELEASE, 2'd1);
    send_word(ACT_TICK, 2'd3);
    repeat (2) begin
      send_word(ACT_PRESS, 2'd1);
      send_word(ACT_RELEASE, 2'd1);
    end
    repeat (3) begin
      send_word(ACT_PRESS, 2'd2);
      send_word(ACT_RELEASE, 2'd2);
    end
    // press while a run is open: the run still times out
    send_word(ACT_RELEASE, 2'd3);
    send_word(ACT_PRESS, 2'd3);
    send_word(ACT_TICK, 2'd0);
    send_word(ACT_RELEASE, 2'd3);
    send_word(ACT_TICK, 2'd2);

    // four runs closing on one tick, then two long presses on one tick
    settle();
    program_regs(4'hF, 4'h0, 4'hF, 16'd100, 16'd2, 1'b1);
    for (int k = 0; k < NUM_KEYS; k++) send_word(ACT_RELEASE, KEY_W'(k));
    repeat (3) send_word(ACT_TICK, pick_key());
    send_word(ACT_PRESS, 2'd0);
    send_word(ACT_PRESS, 2'd1);
    repeat (100) send_word(ACT_TICK, pick_key());
    send_word(ACT_RELEASE, 2'd0);
    send_word(ACT_RELEASE, 2'd1);

    for (int ph = 0; ph < 5; ph++) begin
      settle();
      case (ph)
        0: begin
          program_regs(4'hF, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                       16'd0, 16'd0, 1'b0);
          burst_cap = 40;
          gap_cap   = 2;
        end
        1: begin
          program_regs(4'($urandom_range(1, 14)), 4'($urandom_range(0, 15)),
                       4'($urandom_range(0, 15)), 16'd100, 16'd3, 1'b1);
          burst_cap = 8;
          gap_cap   = 8;
        end
        2: begin
          program_regs(4'hF, 4'hF, 4'h0, 16'($urandom_range(101, 125)),
                       16'($urandom_range(0, 6)), 1'($urandom_range(0, 1)));
          burst_cap = 16;
          gap_cap   = 4;
        end
        3: begin
          program_regs(4'($urandom_range(1, 14)), 4'($urandom_range(0, 15)),
                       4'($urandom_range(0, 15)), 16'd100, 16'hFFFF,
                       1'($urandom_range(0, 1)));
          burst_cap = 4;
          gap_cap   = 12;
        end
        default: begin
          program_regs(4'hF, 4'h0, 4'hF, 16'd100, 16'd1, 1'b0);
          burst_cap = 1000;
          gap_cap   = 1;
        end
      endcase
      repeat (PHASE_STEPS) random_step();
    end

    settle();
    if (fail_count == 0 && due_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/kgc_pkg.sv
sv/kgc_state_ram.sv
sv/kgc_key_update.sv
sv/kgc_result_q.sv
sv/key_gesture_classifier.sv
verif/kgc_checker.sv
verif/tb_key_gesture_classifier.sv
